>>> rtl/ppsd_pkg.sv
// shared types and constants of the packed pose sample decoder
package ppsd_pkg;

  // field and datapath widths
  localparam int CODE_W  = 16;
  localparam int MAG_W   = 17;
  localparam int SUM_W   = 32;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int POS_W   = 32;
  localparam int PROD_W  = 49;
  localparam int QUAT_W  = 18;
  localparam int QUATW_W = 17;
  localparam int DEN_W   = 32;

  // rotation dequantization: (code - mid) * 21 / 655350
  localparam int ROT_MID = 32767;
  localparam int ROT_NUM = 21;
  localparam int ROT_DEN = 655350;
  localparam int ROT_DEN_HALF = 327675;
  localparam int LEN_K = 441;
  localparam logic [RAD_W-1:0] LEN_LIMIT = 64'd429483622500;

  // w divisor is ROT_DEN scaled by 2^12
  localparam logic [DEN_W-1:0] W_DEN      = 32'd2684313600;
  localparam logic [DEN_W-1:0] W_DEN_HALF = 32'd1342156800;

  // output clamps
  localparam int QUAT_MAX  = 131071;
  localparam int QUAT_MIN  = -131072;
  localparam int QUATW_MAX = 131071;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POS_SCALE  = 2'd0;
  localparam cfg_idx_t CFG_POS_OFFSET = 2'd1;
  localparam logic [POS_W-1:0] POS_SCALE_RST  = 32'd65536;
  localparam logic [POS_W-1:0] POS_OFFSET_RST = 32'd0;

  // data riding along the square root pipeline
  typedef struct packed {
    logic                        norm;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
    logic [2:0][POS_W-1:0]       pos;
  } rot_sb_t;

  // data riding along the divider pipeline
  typedef struct packed {
    logic [2:0]                  neg;
    logic [2:0][POS_W-1:0]       pos;
  } div_sb_t;

endpackage

>>> rtl/ppsd_front.sv
// front stages: rotation magnitudes, length test, radicand and positions
module ppsd_front
  import ppsd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ce,
  input  logic                    in_valid,
  input  logic [CODE_W-1:0]       rot_code [3],
  input  logic [CODE_W-1:0]       pos_code [3],
  input  logic signed [POS_W-1:0] pos_scale,
  input  logic signed [POS_W-1:0] pos_offset,
  output logic                    fr_valid,
  output logic [RAD_W-1:0]        fr_rad,
  output rot_sb_t                 fr_sb
);

  logic                     v1_r;
  logic [MAG_W-1:0]         mag1_r [3];
  logic [2:0]               neg1_r;
  logic [SUM_W-1:0]         sum1_r;
  logic signed [PROD_W-1:0] prod1_r [3];

  logic [MAG_W-1:0]         mag1_nxt [3];
  logic [2:0]               neg1_nxt;
  logic [SUM_W-1:0]         sum1_nxt;
  logic signed [PROD_W-1:0] prod1_nxt [3];

  logic                     v2_r;
  logic [RAD_W-1:0]         rad2_r;
  rot_sb_t                  sb2_r;
  logic [RAD_W-1:0]         rad2_nxt;
  rot_sb_t                  sb2_nxt;

  // stage 1: signed offsets, squares and position products
  always_comb begin
    logic [17:0] d;
    logic [33:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      d = 18'({2'b00, rot_code[i]}) - 18'(ROT_MID);
      neg1_nxt[i] = d[17];
      mag1_nxt[i] = d[17] ? MAG_W'(-d) : MAG_W'(d);
      acc = acc + 34'(mag1_nxt[i]) * 34'(mag1_nxt[i]);
      prod1_nxt[i] = $signed({1'b0, pos_code[i]}) * pos_scale;
    end
    sum1_nxt = acc[SUM_W-1:0];
  end

  // stage 2: length test, radicand select, offset and clamp
  always_comb begin
    logic [40:0]       t;
    logic signed [49:0] p;
    t = 41'(sum1_r) * 41'(LEN_K);
    sb2_nxt.norm = (64'(t) > LEN_LIMIT);
    sb2_nxt.neg  = neg1_r;
    if (sb2_nxt.norm) begin
      rad2_nxt = {2'b00, sum1_r, 30'b0};
    end else begin
      rad2_nxt = (LEN_LIMIT - 64'(t)) << 24;
    end
    for (int i = 0; i < 3; i++) begin
      sb2_nxt.mag[i] = mag1_r[i];
      p = 50'(prod1_r[i]) + 50'(pos_offset);
      if (p > 50'(POS_MAX)) begin
        sb2_nxt.pos[i] = POS_W'(POS_MAX);
      end else if (p < 50'(POS_MIN)) begin
        sb2_nxt.pos[i] = POS_W'(POS_MIN);
      end else begin
        sb2_nxt.pos[i] = p[POS_W-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ce) begin
      mag1_r  <= mag1_nxt;
      neg1_r  <= neg1_nxt;
      sum1_r  <= sum1_nxt;
      prod1_r <= prod1_nxt;
      rad2_r  <= rad2_nxt;
      sb2_r   <= sb2_nxt;
    end
  end

  assign fr_valid = v2_r;
  assign fr_rad   = rad2_r;
  assign fr_sb    = sb2_r;

endmodule

>>> rtl/ppsd_isqrt.sv
// pipelined integer square root, one result bit per stage
module ppsd_isqrt #(
  parameter int RAD_W = 64,
  parameter int SBW   = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ce,
  input  logic               in_valid,
  input  logic [RAD_W-1:0]   in_rad,
  input  logic [SBW-1:0]     in_sb,
  output logic               out_valid,
  output logic [RAD_W/2-1:0] out_root,
  output logic [SBW-1:0]     out_sb
);

  localparam int NST   = RAD_W / 2;
  localparam int ROOTW = RAD_W / 2;
  localparam int REMW  = ROOTW + 2;

  logic             v_r    [NST];
  logic [RAD_W-1:0] rad_r  [NST];
  logic [REMW-1:0]  rem_r  [NST];
  logic [ROOTW-1:0] root_r [NST];
  logic [SBW-1:0]   sb_r   [NST];

  logic [RAD_W-1:0] rad_nxt  [NST];
  logic [REMW-1:0]  rem_nxt  [NST];
  logic [ROOTW-1:0] root_nxt [NST];

  // one digit pair per stage: trial subtract of 4*root+1
  always_comb begin
    logic [RAD_W-1:0] s_rad;
    logic [REMW-1:0]  s_rem;
    logic [ROOTW-1:0] s_root;
    logic [REMW-1:0]  sh;
    logic [REMW-1:0]  trial;
    for (int k = 0; k < NST; k++) begin
      s_rad  = (k == 0) ? in_rad : rad_r[k-1];
      s_rem  = (k == 0) ? '0 : rem_r[k-1];
      s_root = (k == 0) ? '0 : root_r[k-1];
      sh     = {s_rem[REMW-3:0], s_rad[RAD_W-1:RAD_W-2]};
      trial  = {s_root, 2'b01};
      rad_nxt[k] = s_rad << 2;
      if (sh >= trial) begin
        rem_nxt[k]  = sh - trial;
        root_nxt[k] = {s_root[ROOTW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = sh;
        root_nxt[k] = {s_root[ROOTW-2:0], 1'b0};
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) v_r[k] <= 1'b0;
    end else if (ce) begin
      for (int k = 0; k < NST; k++) v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NST; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        sb_r[k]   <= (k == 0) ? in_sb : sb_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_root  = root_r[NST-1];
  assign out_sb    = sb_r[NST-1];

endmodule

>>> rtl/ppsd_div.sv
// pipelined restoring divider, several lanes, one quotient bit per stage
module ppsd_div #(
  parameter int NW    = 49,
  parameter int DW    = 32,
  parameter int QW    = 18,
  parameter int LANES = 4,
  parameter int SBW   = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ce,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_num [LANES],
  input  logic [DW-1:0]  in_den [LANES],
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [QW-1:0]  out_q [LANES],
  output logic [SBW-1:0] out_sb
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic           v_r   [QW];
  logic [SBW-1:0] sb_r  [QW];
  logic [NW-1:0]  rem_r [QW][LANES];
  logic [DW-1:0]  den_r [QW][LANES];
  logic [QW-1:0]  q_r   [QW][LANES];

  logic [NW-1:0]  rem_nxt [QW][LANES];
  logic [QW-1:0]  q_nxt   [QW][LANES];

  // quotient bit QW-1-k is decided in stage k
  always_comb begin
    logic [NW-1:0] s_rem;
    logic [DW-1:0] s_den;
    logic [QW-1:0] s_q;
    logic [CW-1:0] dsh;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      for (int j = 0; j < LANES; j++) begin
        s_rem = (k == 0) ? in_num[j] : rem_r[k-1][j];
        s_den = (k == 0) ? in_den[j] : den_r[k-1][j];
        s_q   = (k == 0) ? '0 : q_r[k-1][j];
        dsh   = CW'(s_den) << (QW - 1 - k);
        ge    = (CW'(s_rem) >= dsh);
        rem_nxt[k][j] = ge ? NW'(CW'(s_rem) - dsh) : s_rem;
        q_nxt[k][j]   = {s_q[QW-2:0], ge};
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) v_r[k] <= 1'b0;
    end else if (ce) begin
      for (int k = 0; k < QW; k++) v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < QW; k++) begin
        sb_r[k] <= (k == 0) ? in_sb : sb_r[k-1];
        for (int j = 0; j < LANES; j++) begin
          rem_r[k][j] <= rem_nxt[k][j];
          q_r[k][j]   <= q_nxt[k][j];
          den_r[k][j] <= (k == 0) ? in_den[j] : den_r[k-1][j];
        end
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_sb    = sb_r[QW-1];

endmodule

>>> rtl/packed_pose_sample_decoder.sv
// top level of the packed pose sample decoder
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_ready | rot_{x,y,z}_code, pos_{x,y,z}_code (16 b)
//  out     | out_valid/out_ready | quat_{x,y,z} (18 b), quat_w (17 b), pos (32 b)
//  cfg     | cfg_valid/cfg_ready | cfg_index (2 b), cfg_data (32 b)
//
// one beat accepted per cycle unless a held result stalls the output; stages:
// two front stages, a 32-stage square root, a setup
// stage, a divider with one quotient bit per stage and the output register.
// the whole pipeline advances together; a stall at the output freezes every stage.
// synchronous reset clears all valid bits and loads the register defaults.
module packed_pose_sample_decoder
  import ppsd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CODE_W-1:0]         in_rot_x_code,
  input  logic [CODE_W-1:0]         in_rot_y_code,
  input  logic [CODE_W-1:0]         in_rot_z_code,
  input  logic [CODE_W-1:0]         in_pos_x_code,
  input  logic [CODE_W-1:0]         in_pos_y_code,
  input  logic [CODE_W-1:0]         in_pos_z_code,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [QUAT_W-1:0]  out_quat_x,
  output logic signed [QUAT_W-1:0]  out_quat_y,
  output logic signed [QUAT_W-1:0]  out_quat_z,
  output logic [QUATW_W-1:0]        out_quat_w,
  output logic signed [POS_W-1:0]   out_pos_x,
  output logic signed [POS_W-1:0]   out_pos_y,
  output logic signed [POS_W-1:0]   out_pos_z,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  cfg_idx_t                  cfg_index,
  input  logic [POS_W-1:0]          cfg_data
);

  localparam int QW = FRAC_BITS + 2;
  localparam int NW = FRAC_BITS + 33;

  logic                    ce;
  logic [POS_W-1:0]        pos_scale_r;
  logic [POS_W-1:0]        pos_offset_r;
  logic [CODE_W-1:0]       rot_code [3];
  logic [CODE_W-1:0]       pos_code [3];

  logic                    fr_valid;
  logic [RAD_W-1:0]        fr_rad;
  rot_sb_t                 fr_sb;

  logic                    sq_valid;
  logic [ROOT_W-1:0]       sq_root;
  logic [$bits(rot_sb_t)-1:0] sq_sb_bits;
  rot_sb_t                 sq_sb;

  logic                    pr_valid_r;
  logic [NW-1:0]           pr_num_r [4];
  logic [DEN_W-1:0]        pr_den_r [4];
  div_sb_t                 pr_sb_r;
  logic [NW-1:0]           pr_num_nxt [4];
  logic [DEN_W-1:0]        pr_den_nxt [4];

  logic                    dv_valid;
  logic [QW-1:0]           dv_q [4];
  logic [$bits(div_sb_t)-1:0] dv_sb_bits;
  div_sb_t                 dv_sb;

  logic                    out_valid_r;
  logic [QUAT_W-1:0]       quat_r [3];
  logic [QUATW_W-1:0]      quat_w_r;
  logic [POS_W-1:0]        pos_r [3];
  logic [QUAT_W-1:0]       quat_nxt [3];
  logic [QUATW_W-1:0]      quat_w_nxt;

  // pipeline advance
  assign ce        = !out_valid_r || out_ready;
  assign in_ready  = ce;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_scale_r  <= POS_SCALE_RST;
      pos_offset_r <= POS_OFFSET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POS_SCALE:  pos_scale_r  <= cfg_data;
        CFG_POS_OFFSET: pos_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rot_code[0] = in_rot_x_code;
  assign rot_code[1] = in_rot_y_code;
  assign rot_code[2] = in_rot_z_code;
  assign pos_code[0] = in_pos_x_code;
  assign pos_code[1] = in_pos_y_code;
  assign pos_code[2] = in_pos_z_code;

  // front stages
  ppsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .ce         (ce),
    .in_valid   (in_valid),
    .rot_code   (rot_code),
    .pos_code   (pos_code),
    .pos_scale  ($signed(pos_scale_r)),
    .pos_offset ($signed(pos_offset_r)),
    .fr_valid   (fr_valid),
    .fr_rad     (fr_rad),
    .fr_sb      (fr_sb)
  );

  // square root of the selected radicand
  ppsd_isqrt #(
    .RAD_W (RAD_W),
    .SBW   ($bits(rot_sb_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (fr_valid),
    .in_rad    (fr_rad),
    .in_sb     (fr_sb),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb_bits)
  );

  assign sq_sb = rot_sb_t'(sq_sb_bits);

  // divider operands: normalized, plain and w lanes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sq_sb.norm) begin
        pr_num_nxt[i] = (NW'(sq_sb.mag[i]) << (FRAC_BITS + 15)) + NW'(sq_root >> 1);
        pr_den_nxt[i] = sq_root;
      end else begin
        pr_num_nxt[i] = ((NW'(sq_sb.mag[i]) * NW'(ROT_NUM)) << FRAC_BITS)
                        + NW'(ROT_DEN_HALF);
        pr_den_nxt[i] = DEN_W'(ROT_DEN);
      end
    end
    pr_num_nxt[3] = sq_sb.norm ? '0 : (NW'(sq_root) << FRAC_BITS) + NW'(W_DEN_HALF);
    pr_den_nxt[3] = W_DEN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_valid_r <= 1'b0;
    end else if (ce) begin
      pr_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pr_num_r    <= pr_num_nxt;
      pr_den_r    <= pr_den_nxt;
      pr_sb_r.neg <= sq_sb.neg;
      pr_sb_r.pos <= sq_sb.pos;
    end
  end

  // quotients for x, y, z and w
  ppsd_div #(
    .NW    (NW),
    .DW    (DEN_W),
    .QW    (QW),
    .LANES (4),
    .SBW   ($bits(div_sb_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (pr_valid_r),
    .in_num    (pr_num_r),
    .in_den    (pr_den_r),
    .in_sb     (pr_sb_r),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_sb    (dv_sb_bits)
  );

  assign dv_sb = div_sb_t'(dv_sb_bits);

  // sign and clamp
  always_comb begin
    logic signed [31:0] qs;
    logic [31:0]        wz;
    for (int i = 0; i < 3; i++) begin
      qs = dv_sb.neg[i] ? -$signed(32'(dv_q[i])) : $signed(32'(dv_q[i]));
      if (qs > 32'(QUAT_MAX)) begin
        quat_nxt[i] = QUAT_W'(QUAT_MAX);
      end else if (qs < 32'(QUAT_MIN)) begin
        quat_nxt[i] = QUAT_W'(QUAT_MIN);
      end else begin
        quat_nxt[i] = qs[QUAT_W-1:0];
      end
    end
    wz = 32'(dv_q[3]);
    quat_w_nxt = (wz > 32'(QUATW_MAX)) ? QUATW_W'(QUATW_MAX) : wz[QUATW_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      quat_r   <= quat_nxt;
      quat_w_r <= quat_w_nxt;
      for (int i = 0; i < 3; i++) pos_r[i] <= dv_sb.pos[i];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_quat_x = $signed(quat_r[0]);
  assign out_quat_y = $signed(quat_r[1]);
  assign out_quat_z = $signed(quat_r[2]);
  assign out_quat_w = quat_w_r;
  assign out_pos_x  = $signed(pos_r[0]);
  assign out_pos_y  = $signed(pos_r[1]);
  assign out_pos_z  = $signed(pos_r[2]);

  // a held result blocks new beats
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // reset empties the output
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stall freezes the setup stage
  a_stall_freezes_setup: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(pr_valid_r))
    else $error("setup stage moved during stall");

  // a finished quotient reaches the output on the next advance
  a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ce && dv_valid |=> out_valid)
    else $error("divider result lost");

endmodule

>>> verif/packed_pose_sample_decoder_checker.sv
// checker that predicts and compares decoded pose beats of the sample decoder
`timescale 1ns / 1ps

module packed_pose_sample_decoder_checker
  import ppsd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [CODE_W-1:0]        in_rot_x_code,
  input  logic [CODE_W-1:0]        in_rot_y_code,
  input  logic [CODE_W-1:0]        in_rot_z_code,
  input  logic [CODE_W-1:0]        in_pos_x_code,
  input  logic [CODE_W-1:0]        in_pos_y_code,
  input  logic [CODE_W-1:0]        in_pos_z_code,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [QUAT_W-1:0] out_quat_x,
  input  logic signed [QUAT_W-1:0] out_quat_y,
  input  logic signed [QUAT_W-1:0] out_quat_z,
  input  logic [QUATW_W-1:0]       out_quat_w,
  input  logic signed [POS_W-1:0]  out_pos_x,
  input  logic signed [POS_W-1:0]  out_pos_y,
  input  logic signed [POS_W-1:0]  out_pos_z,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [POS_W-1:0]         cfg_data,
  output int                       mismatches,
  output int                       pending
);

  typedef struct {
    logic signed [QUAT_W-1:0] qx, qy, qz;
    logic [QUATW_W-1:0]       qw;
    logic signed [POS_W-1:0]  px, py, pz;
  } pose_t;

  pose_t pose_q[$];
  logic signed [POS_W-1:0] scale_reg, offset_reg;

  assign pending = pose_q.size();

  // bitwise integer square root
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [QUAT_W-1:0] quat_clip(input longint v);
    if (v > QUAT_MAX) v = QUAT_MAX;
    if (v < QUAT_MIN) v = QUAT_MIN;
    return v[QUAT_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] scale_pos(input logic [CODE_W-1:0] c);
    longint p;
    p = longint'(c) * longint'(scale_reg) + longint'(offset_reg);
    if (p > POS_MAX) p = POS_MAX;
    if (p < POS_MIN) p = POS_MIN;
    return p[POS_W-1:0];
  endfunction

  // rotation and position decode of one sample
  function automatic pose_t decode_pose(input logic [CODE_W-1:0] rx, ry, rz, px, py, pz);
    pose_t e;
    int d[3];
    longint unsigned mag[3], s, lim, r, num, n, r2, den, wv;
    longint q[3];
    d[0] = int'(rx) - ROT_MID;
    d[1] = int'(ry) - ROT_MID;
    d[2] = int'(rz) - ROT_MID;
    s = 0;
    lim = longint'(ROT_DEN) * ROT_DEN;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      s += mag[i] * mag[i];
    end
    if (s * LEN_K > lim) begin
      r = int_sqrt(s << 30);
      for (int i = 0; i < 3; i++) begin
        num = mag[i] << (FRAC_BITS + 15);
        q[i] = longint'((num + r / 2) / r);
        if (d[i] < 0) q[i] = -q[i];
      end
      wv = 0;
    end else begin
      n = lim - s * LEN_K;
      r2 = int_sqrt(n << 24);
      den = longint'(ROT_DEN) << 12;
      for (int i = 0; i < 3; i++) begin
        num = (mag[i] * ROT_NUM) << FRAC_BITS;
        q[i] = longint'((num + ROT_DEN / 2) / ROT_DEN);
        if (d[i] < 0) q[i] = -q[i];
      end
      wv = ((r2 << FRAC_BITS) + den / 2) / den;
    end
    if (wv > QUATW_MAX) wv = QUATW_MAX;
    e.qx = quat_clip(q[0]);
    e.qy = quat_clip(q[1]);
    e.qz = quat_clip(q[2]);
    e.qw = wv[QUATW_W-1:0];
    e.px = scale_pos(px);
    e.py = scale_pos(py);
    e.pz = scale_pos(pz);
    return e;
  endfunction

  // register writes, sample beats and result beats
  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      scale_reg  <= POS_SCALE_RST;
      offset_reg <= POS_OFFSET_RST;
      pose_q.delete();
      mismatches <= 0;
    end else begin
      if (in_valid && in_ready)
        pose_q.push_back(decode_pose(in_rot_x_code, in_rot_y_code, in_rot_z_code,
                                     in_pos_x_code, in_pos_y_code, in_pos_z_code));
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat at %0t", $time);
          mismatches <= mismatches + 1;
        end else begin
          e = pose_q.pop_front();
          if (e.qx !== out_quat_x || e.qy !== out_quat_y || e.qz !== out_quat_z ||
              e.qw !== out_quat_w || e.px !== out_pos_x || e.py !== out_pos_y ||
              e.pz !== out_pos_z) begin
            if (mismatches < 10)
              $display("pose mismatch at %0t: exp q %0d %0d %0d %0d p %0d %0d %0d, got q %0d %0d %0d %0d p %0d %0d %0d",
                       $time, e.qx, e.qy, e.qz, e.qw, e.px, e.py, e.pz,
                       out_quat_x, out_quat_y, out_quat_z, out_quat_w,
                       out_pos_x, out_pos_y, out_pos_z);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_POS_SCALE) scale_reg <= cfg_data;
        else if (cfg_index == CFG_POS_OFFSET) offset_reg <= cfg_data;
      end
    end
  end

endmodule

>>> verif/packed_pose_sample_decoder_test.sv
// stimulus and verdict for the packed pose sample decoder
`timescale 1ns / 1ps

module packed_pose_sample_decoder_test;
  import ppsd_pkg::*;

  localparam int LATENCY   = 54;
  localparam int WD_LIMIT  = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic in_ready, out_valid, cfg_ready;
  logic [CODE_W-1:0] rx = '0, ry = '0, rz = '0, px = '0, py = '0, pz = '0;
  logic signed [QUAT_W-1:0] qx, qy, qz;
  logic [QUATW_W-1:0] qw;
  logic signed [POS_W-1:0] opx, opy, opz;
  cfg_idx_t cfg_index = CFG_POS_SCALE;
  logic [POS_W-1:0] cfg_data = '0;
  int mismatches, pending;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0;
  int quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  packed_pose_sample_decoder DUT (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_rot_x_code(rx), .in_rot_y_code(ry), .in_rot_z_code(rz),
    .in_pos_x_code(px), .in_pos_y_code(py), .in_pos_z_code(pz),
    .out_valid, .out_ready,
    .out_quat_x(qx), .out_quat_y(qy), .out_quat_z(qz), .out_quat_w(qw),
    .out_pos_x(opx), .out_pos_y(opy), .out_pos_z(opz),
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  packed_pose_sample_decoder_checker chk (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_rot_x_code(rx), .in_rot_y_code(ry), .in_rot_z_code(rz),
    .in_pos_x_code(px), .in_pos_y_code(py), .in_pos_z_code(pz),
    .out_valid, .out_ready,
    .out_quat_x(qx), .out_quat_y(qy), .out_quat_z(qz), .out_quat_w(qw),
    .out_pos_x(opx), .out_pos_y(opy), .out_pos_z(opz),
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .pending
  );

  // receiver: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles with no beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [POS_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // one sample beat, with random gap before it; valid stays up for a following beat
  task automatic send_sample(input logic [CODE_W-1:0] a, b, c, d, e, f);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    rx <= a; ry <= b; rz <= c; px <= d; py <= e; pz <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [CODE_W-1:0] rnd_code();
    case ($urandom_range(5))
      0: return 16'(32767 + $urandom_range(2000) - 1000);
      1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      2: return 16'(32767 + $urandom_range(40000) - 20000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count)
      send_sample(rnd_code(), rnd_code(), rnd_code(), 16'($urandom), 16'($urandom),
                  $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom));
  endtask

  // end the sample stream and let the pipeline drain before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: code extremes, center, unit-length boundary area, default registers
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'd32767, 16'd32767, 16'd32767, 16'd1, 16'd2, 16'd3);
    send_sample(16'd32768, 16'd32766, 16'd32767, 16'h8000, 16'h7FFF, 16'h5555);
    send_sample(16'hFFFF, 16'd32767, 16'd32767, 16'hAAAA, 16'h0001, 16'hFFFE);
    send_sample(16'h0000, 16'd32767, 16'd32767, 16'h1234, 16'h0000, 16'h0000);
    send_sample(16'd32767 + 16'd31207, 16'd32767, 16'd32767, 16'd0, 16'd0, 16'd0);
    send_sample(16'd32767 + 16'd31208, 16'd32767, 16'd32767, 16'd0, 16'd0, 16'd0);
    send_sample(16'd32767 - 16'd18020, 16'd32767 + 16'd18020, 16'd32767 - 16'd18020,
                16'd7, 16'd8, 16'd9);
    send_sample(16'd32767 + 16'd22070, 16'd32767 - 16'd22070, 16'd32767,
                16'd100, 16'd200, 16'd300);
    drain();

    // register extremes, saturation both ways
    write_reg(CFG_POS_SCALE, 32'h7FFFFFFF);
    write_reg(CFG_POS_OFFSET, 32'h7FFFFFFF);
    send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'hFFFF);
    drain();
    write_reg(CFG_POS_SCALE, 32'h80000000);
    write_reg(CFG_POS_OFFSET, 32'h80000000);
    send_sample(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
    drain();
    write_reg(CFG_POS_SCALE, 32'h00000000);
    write_reg(CFG_POS_OFFSET, 32'hFFFFFFFF);
    send_sample(16'd1, 16'd2, 16'd3, 16'd0, 16'd1, 16'hFFFF);
    drain();
    cfg_index <= cfg_idx_t'(2'd3);
    cfg_data  <= 32'hDEADBEEF;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_sample(16'd5, 16'd6, 16'd7, 16'd8, 16'd9, 16'd10);
    drain();

    // sender idles 31, receiver 70; long receiver hold-off at the start
    send_idle = 31; recv_idle = 70;
    write_reg(CFG_POS_SCALE, 32'hFFFF0000);
    write_reg(CFG_POS_OFFSET, 32'h00012345);
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      send_random(500);
    join
    drain();

    send_idle = 70; recv_idle = 31;
    write_reg(CFG_POS_SCALE, $urandom);
    write_reg(CFG_POS_OFFSET, $urandom);
    send_random(500);
    drain();

    send_idle = 0; recv_idle = 0;
    write_reg(CFG_POS_SCALE, 32'h00010000 + $urandom_range(65535));
    write_reg(CFG_POS_OFFSET, $urandom);
    send_random(500);
    drain();

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/ppsd_pkg.sv
rtl/ppsd_front.sv
rtl/ppsd_isqrt.sv
rtl/ppsd_div.sv
rtl/packed_pose_sample_decoder.sv
verif/packed_pose_sample_decoder_checker.sv
verif/packed_pose_sample_decoder_test.sv
